// ===== design/bbs_pkg.sv =====
`default_nettype none

package bbs_pkg;

    localparam int BLK_W      = 17;
    localparam int DIM_W      = 13;
    localparam int POS_W      = 12;
    localparam int SUM_W      = 24;
    localparam int QUO_W      = 9;
    localparam int DIV_CNT_W  = 4;
    localparam int DIV_STEPS  = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [BLK_W-1:0] MAX_BLOCK   = BLK_W'(65536);
    localparam logic [DIM_W-1:0] MAX_DIM     = DIM_W'(4096);
    localparam logic [BLK_W-1:0] RESET_BLOCK = BLK_W'(4096);
    localparam logic [DIM_W-1:0] RESET_LINE  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RESET_FRAME = DIM_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_BYTES,
        REG_LINE_PIXELS,
        REG_FRAME_LINES,
        REG_WATERFALL
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DIV,
        ST_WAIT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic blk_done;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== design/byte_block_stats_to_pixel.sv =====
// Byte block statistics to pixel.
// Bytes arrive on the input channel (in_valid, in_stall, data_byte); a transfer
// takes place at a clock edge with in_valid high and in_stall low. Every
// block_bytes bytes (0 taken as 1, above 65536 as 65536) give one pixel on the
// output channel (out_valid, out_stall, red, green, blue, pixel_x, pixel_y,
// scroll_line), transferred at an edge with out_valid high and out_stall low.
// Bytes inside a block are taken one per cycle. The transfer that completes a
// block starts two 9-step restoring dividers that share the block size as
// divisor; the pixel is loaded into the output register when the division
// ends and the register is free, and the input stalls meanwhile.
// A pixel waiting in the output register does not hold up the next block;
// a stalled receiver stops the block only when the next pixel is ready and
// the register is still occupied. Configuration transfers on the cfg channel
// are always taken and should be made while the block is idle; a write of
// block_bytes drops the partial block.
// Reset clears all counters and positions and restores the register defaults
// (block 4096 bytes, 640 pixels per line, 480 lines, raster mode).

`default_nettype none

module byte_block_stats_to_pixel (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [7:0]                        data_byte,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [7:0]                             red,
    output logic [7:0]                             green,
    output logic [7:0]                             blue,
    output logic [bbs_pkg::POS_W-1:0]              pixel_x,
    output logic [bbs_pkg::POS_W-1:0]              pixel_y,
    output logic                                   scroll_line,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bbs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bbs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    bbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    bbs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .data_byte   (data_byte),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .scroll_line (scroll_line)
    );

endmodule

`default_nettype wire

// ===== design/bbs_ctrl.sv =====
`default_nettype none

module bbs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  bbs_pkg::dp_status_t     status,
    output bbs_pkg::ctrl_cmd_t      cmd,
    output logic                    in_stall
);
    import bbs_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCUM:
            begin
                if (in_valid && status.blk_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_ACCUM:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_WAIT:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/bbs_datapath.sv =====
`default_nettype none

module bbs_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  bbs_pkg::ctrl_cmd_t                     cmd,
    output bbs_pkg::dp_status_t                    status,
    input  wire logic [7:0]                        data_byte,
    input  wire logic                              cfg_write,
    input  wire logic [bbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bbs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              out_stall,
    output logic                                   out_valid,
    output logic [7:0]                             red,
    output logic [7:0]                             green,
    output logic [7:0]                             blue,
    output logic [bbs_pkg::POS_W-1:0]              pixel_x,
    output logic [bbs_pkg::POS_W-1:0]              pixel_y,
    output logic                                   scroll_line
);
    import bbs_pkg::*;

    logic [BLK_W-1:0] block_bytes_reg;
    logic [DIM_W-1:0] line_pixels_reg;
    logic [DIM_W-1:0] frame_lines_reg;
    logic             waterfall_reg;

    logic [BLK_W-1:0] count_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [7:0]       xor_reg;
    logic [BLK_W-1:0] nz_reg;
    logic [POS_W-1:0] column_reg;
    logic [POS_W-1:0] row_reg;

    logic [BLK_W-1:0] rem_red_reg;
    logic [QUO_W-1:0] quo_red_reg;
    logic [BLK_W-1:0] rem_blue_reg;
    logic [QUO_W-1:0] quo_blue_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic [7:0]       green_pend_reg;
    logic [POS_W-1:0] px_pend_reg;
    logic [POS_W-1:0] py_pend_reg;
    logic             scroll_pend_reg;

    logic             out_valid_reg;
    logic [7:0]       red_reg;
    logic [7:0]       green_reg;
    logic [7:0]       blue_reg;
    logic [POS_W-1:0] px_reg;
    logic [POS_W-1:0] py_reg;
    logic             scroll_reg;

    logic [BLK_W-1:0] blk;
    logic [DIM_W-1:0] lin;
    logic [DIM_W-1:0] frm;
    logic [BLK_W:0]   count_inc;
    logic [SUM_W-1:0] sum_next;
    logic [7:0]       xor_next;
    logic [BLK_W-1:0] nz_next;
    logic             blk_done;

    logic [POS_W-1:0] col_eff;
    logic [POS_W-1:0] row_eff;
    logic [DIM_W-1:0] col_plus;
    logic [DIM_W-1:0] row_plus;
    logic             line_end;
    logic             frame_end;
    logic [POS_W-1:0] column_next;
    logic [POS_W-1:0] row_next;
    logic [POS_W-1:0] py_next;
    logic             scroll_next;

    logic [BLK_W:0]   t_red;
    logic [BLK_W:0]   t_blue;
    logic             ge_red;
    logic             ge_blue;
    logic [BLK_W:0]   d_red;
    logic [BLK_W:0]   d_blue;

    always_comb
    begin
        if (block_bytes_reg == '0)
        begin
            blk = BLK_W'(1);
        end
        else if (block_bytes_reg > MAX_BLOCK)
        begin
            blk = MAX_BLOCK;
        end
        else
        begin
            blk = block_bytes_reg;
        end

        if (line_pixels_reg == '0)
        begin
            lin = DIM_W'(1);
        end
        else if (line_pixels_reg > MAX_DIM)
        begin
            lin = MAX_DIM;
        end
        else
        begin
            lin = line_pixels_reg;
        end

        if (frame_lines_reg == '0)
        begin
            frm = DIM_W'(1);
        end
        else if (frame_lines_reg > MAX_DIM)
        begin
            frm = MAX_DIM;
        end
        else
        begin
            frm = frame_lines_reg;
        end
    end

    assign count_inc = {1'b0, count_reg} + (BLK_W+1)'(1);
    assign sum_next  = sum_reg + SUM_W'(data_byte);
    assign xor_next  = xor_reg ^ data_byte;
    assign nz_next   = nz_reg + BLK_W'(data_byte != 8'd0);
    assign blk_done  = count_inc >= {1'b0, blk};

    always_comb
    begin
        col_eff     = ({1'b0, column_reg} >= lin) ? '0 : column_reg;
        row_eff     = ({1'b0, row_reg} >= frm) ? '0 : row_reg;
        col_plus    = {1'b0, col_eff} + DIM_W'(1);
        row_plus    = {1'b0, row_eff} + DIM_W'(1);
        line_end    = col_plus >= lin;
        frame_end   = row_plus >= frm;
        column_next = line_end ? '0 : col_plus[POS_W-1:0];
        if (waterfall_reg)
        begin
            py_next     = '0;
            scroll_next = line_end;
            row_next    = row_reg;
        end
        else
        begin
            py_next     = row_eff;
            scroll_next = 1'b0;
            if (line_end)
            begin
                row_next = frame_end ? '0 : row_plus[POS_W-1:0];
            end
            else
            begin
                row_next = row_eff;
            end
        end
    end

    assign t_red   = {rem_red_reg, quo_red_reg[QUO_W-1]};
    assign t_blue  = {rem_blue_reg, quo_blue_reg[QUO_W-1]};
    assign ge_red  = t_red >= {1'b0, blk};
    assign ge_blue = t_blue >= {1'b0, blk};
    assign d_red   = t_red - {1'b0, blk};
    assign d_blue  = t_blue - {1'b0, blk};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg <= RESET_BLOCK;
            line_pixels_reg <= RESET_LINE;
            frame_lines_reg <= RESET_FRAME;
            waterfall_reg   <= 1'b0;
            count_reg       <= '0;
            sum_reg         <= '0;
            xor_reg         <= '0;
            nz_reg          <= '0;
            column_reg      <= '0;
            row_reg         <= '0;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_BLOCK_BYTES:
                    begin
                        block_bytes_reg <= cfg_data[BLK_W-1:0];
                        count_reg       <= '0;
                        sum_reg         <= '0;
                        xor_reg         <= '0;
                        nz_reg          <= '0;
                    end
                    REG_LINE_PIXELS:
                    begin
                        line_pixels_reg <= cfg_data[DIM_W-1:0];
                    end
                    REG_FRAME_LINES:
                    begin
                        frame_lines_reg <= cfg_data[DIM_W-1:0];
                    end
                    REG_WATERFALL:
                    begin
                        waterfall_reg <= cfg_data[0];
                    end
                    default:
                    begin
                        waterfall_reg <= waterfall_reg;
                    end
                endcase
            end
            else if (cmd.accept)
            begin
                if (blk_done)
                begin
                    count_reg   <= '0;
                    sum_reg     <= '0;
                    xor_reg     <= '0;
                    nz_reg      <= '0;
                    column_reg  <= column_next;
                    row_reg     <= row_next;
                    div_cnt_reg <= '0;
                end
                else
                begin
                    count_reg <= count_inc[BLK_W-1:0];
                    sum_reg   <= sum_next;
                    xor_reg   <= xor_next;
                    nz_reg    <= nz_next;
                end
            end

            if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && blk_done && !cfg_write)
        begin
            rem_red_reg     <= BLK_W'(sum_next[SUM_W-1:QUO_W]);
            quo_red_reg     <= sum_next[QUO_W-1:0];
            rem_blue_reg    <= BLK_W'(nz_next[BLK_W-1:1]);
            quo_blue_reg    <= {nz_next[0], 8'd0};
            green_pend_reg  <= xor_next;
            px_pend_reg     <= col_eff;
            py_pend_reg     <= py_next;
            scroll_pend_reg <= scroll_next;
        end
        else if (cmd.div_step)
        begin
            rem_red_reg  <= ge_red ? d_red[BLK_W-1:0] : t_red[BLK_W-1:0];
            quo_red_reg  <= {quo_red_reg[QUO_W-2:0], ge_red};
            rem_blue_reg <= ge_blue ? d_blue[BLK_W-1:0] : t_blue[BLK_W-1:0];
            quo_blue_reg <= {quo_blue_reg[QUO_W-2:0], ge_blue};
        end

        if (cmd.out_load)
        begin
            red_reg    <= quo_red_reg[QUO_W-1] ? 8'hFF : quo_red_reg[7:0];
            blue_reg   <= quo_blue_reg[QUO_W-1] ? 8'hFF : quo_blue_reg[7:0];
            green_reg  <= green_pend_reg;
            px_reg     <= px_pend_reg;
            py_reg     <= py_pend_reg;
            scroll_reg <= scroll_pend_reg;
        end
    end

    assign status.blk_done = blk_done;
    assign status.div_last = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign scroll_line = scroll_reg;

endmodule

`default_nettype wire

// ===== test/byte_block_stats_to_pixel_test.sv =====
module byte_block_stats_to_pixel_test;
    import bbs_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             scroll;
    } pixel_t;

    class block_stats;
        logic [BLK_W-1:0] block_reg;
        logic [DIM_W-1:0] line_reg;
        logic [DIM_W-1:0] frame_reg;
        logic             waterfall;
        int unsigned      byte_total;
        int unsigned      sum;
        int unsigned      nonzero;
        logic [7:0]       parity;
        int unsigned      column;
        int unsigned      row;
        pixel_t           pending_pixels[$];
        int               failures;

        function new();
            block_reg = RESET_BLOCK;
            line_reg = RESET_LINE;
            frame_reg = RESET_FRAME;
            waterfall = 1'b0;
            column = 0;
            row = 0;
            failures = 0;
            clear_block();
        endfunction

        function void clear_block();
            byte_total = 0;
            sum = 0;
            nonzero = 0;
            parity = 8'h00;
        endfunction

        function int unsigned effective(int unsigned v, int unsigned top);
            if (v == 0)
            begin
                return 1;
            end
            return (v > top) ? top : v;
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_BLOCK_BYTES:
                begin
                    block_reg = value[BLK_W-1:0];
                    clear_block();
                end
                REG_LINE_PIXELS: line_reg = value[DIM_W-1:0];
                REG_FRAME_LINES: frame_reg = value[DIM_W-1:0];
                REG_WATERFALL:   waterfall = value[0];
                default: ;
            endcase
        endfunction

        function void take_byte(logic [7:0] d);
            int unsigned blk;
            int unsigned lin;
            int unsigned frm;
            pixel_t p;
            blk = effective(block_reg, MAX_BLOCK);
            lin = effective(line_reg, MAX_DIM);
            frm = effective(frame_reg, MAX_DIM);
            byte_total++;
            sum += d;
            parity ^= d;
            if (d != 0)
            begin
                nonzero++;
            end
            if (byte_total < blk)
            begin
                return;
            end
            p.red = (sum / blk > 255) ? 8'd255 : 8'(sum / blk);
            p.green = parity;
            p.blue = ((nonzero * 256) / blk > 255) ? 8'd255 : 8'((nonzero * 256) / blk);
            p.scroll = 1'b0;
            if (column >= lin)
            begin
                column = 0;
            end
            p.x = POS_W'(column);
            if (waterfall)
            begin
                p.y = '0;
                if (column + 1 >= lin)
                begin
                    column = 0;
                    p.scroll = 1'b1;
                end
                else
                begin
                    column = column + 1;
                end
            end
            else
            begin
                if (row >= frm)
                begin
                    row = 0;
                end
                p.y = POS_W'(row);
                if (column + 1 >= lin)
                begin
                    column = 0;
                    row = (row + 1 >= frm) ? 0 : row + 1;
                end
                else
                begin
                    column = column + 1;
                end
            end
            pending_pixels.push_back(p);
            clear_block();
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pending_pixels.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("unexpected pixel r=%0d g=%0d b=%0d x=%0d y=%0d s=%0d",
                             got.red, got.green, got.blue, got.x, got.y, got.scroll);
                end
                return;
            end
            want = pending_pixels.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue
                || got.x !== want.x || got.y !== want.y || got.scroll !== want.scroll)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("pixel mismatch: expected r=%0d g=%0d b=%0d x=%0d y=%0d s=%0d",
                             want.red, want.green, want.blue, want.x, want.y, want.scroll);
                    $display("                actual   r=%0d g=%0d b=%0d x=%0d y=%0d s=%0d",
                             got.red, got.green, got.blue, got.x, got.y, got.scroll);
                end
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            data_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [POS_W-1:0]      pixel_x;
    logic [POS_W-1:0]      pixel_y;
    logic                  scroll_line;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic                  hold_req;
    logic                  no_gaps;
    block_stats            stats;

    byte_block_stats_to_pixel u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .scroll_line (scroll_line),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("** byte_block_stats_to_pixel: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
        begin
            stats.set_register(cfg_reg_t'(cfg_index), cfg_data);
        end
        if (in_valid && !in_stall)
        begin
            stats.take_byte(data_byte);
        end
        if (out_valid && !out_stall)
        begin
            stats.check_pixel({red, green, blue, pixel_x, pixel_y, scroll_line});
        end
    end

    initial
    begin : receiver
        int r;
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    out_stall = 1'b0;
                    n = $urandom_range(1, 20);
                end
                else if (r < 95)
                begin
                    out_stall = 1'b1;
                    n = $urandom_range(1, 3);
                end
                else
                begin
                    out_stall = 1'b1;
                    n = $urandom_range(10, 40);
                end
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return 0;
        end
        if (r < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            return 8'h00;
        end
        if (r < 25)
        begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_block();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            return '0;
        end
        if (r < 80)
        begin
            return CFG_DATA_W'($urandom_range(1, 6));
        end
        return CFG_DATA_W'($urandom_range(7, 40));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        int r;
        logic [CFG_DATA_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            v = '0;
        end
        else if (r < 75)
        begin
            v = CFG_DATA_W'($urandom_range(1, 6));
        end
        else if (r < 90)
        begin
            v = CFG_DATA_W'($urandom_range(7, 30));
        end
        else
        begin
            v = CFG_DATA_W'($urandom_range(4090, 8191));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            v[CFG_DATA_W-1:DIM_W] = 4'($urandom_range(0, 15));
        end
        return v;
    endfunction

    task automatic send_byte(input logic [7:0] d);
        int gap;
        @(negedge clk);
        in_valid = 1'b1;
        data_byte = d;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (stats.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin : stimulus
        int i;
        int ph;
        stats = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = REG_BLOCK_BYTES;
        cfg_data = '0;
        hold_req = 1'b0;
        no_gaps = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < 100; i++)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end

        settle();
        write_reg(REG_BLOCK_BYTES, 1);
        write_reg(REG_LINE_PIXELS, 3);
        write_reg(REG_FRAME_LINES, 2);
        write_reg(REG_WATERFALL, 0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h7F);
        send_byte(8'hAA);
        send_byte(8'h55);

        settle();
        write_reg(REG_LINE_PIXELS, 1);
        send_byte(8'h3C);
        settle();
        write_reg(REG_FRAME_LINES, 1);
        send_byte(8'hC3);

        settle();
        write_reg(REG_BLOCK_BYTES, 0);
        write_reg(REG_LINE_PIXELS, 0);
        write_reg(REG_FRAME_LINES, 0);
        send_byte(8'h10);
        send_byte(8'h00);

        settle();
        write_reg(REG_BLOCK_BYTES, 3);
        write_reg(REG_LINE_PIXELS, 2);
        write_reg(REG_WATERFALL, CFG_DATA_W'(17'h1FFFF));
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'hFF);
        settle();
        write_reg(REG_BLOCK_BYTES, 2);
        send_byte(8'hFF);
        send_byte(8'hFF);

        settle();
        write_reg(REG_BLOCK_BYTES, 1);
        write_reg(REG_LINE_PIXELS, 5);
        write_reg(REG_FRAME_LINES, 3);
        write_reg(REG_WATERFALL, 0);
        hold_req = 1'b1;
        no_gaps = 1'b1;
        for (i = 0; i < 40; i++)
        begin
            send_byte(pick_byte());
        end
        no_gaps = 1'b0;

        settle();
        write_reg(REG_BLOCK_BYTES, CFG_DATA_W'(17'h10000));
        for (i = 0; i < 100; i++)
        begin
            send_byte(pick_byte());
        end
        settle();
        write_reg(REG_BLOCK_BYTES, CFG_DATA_W'(17'h1FFFF));
        write_reg(REG_LINE_PIXELS, CFG_DATA_W'(17'h01000));
        write_reg(REG_FRAME_LINES, CFG_DATA_W'(17'h1FFFF));
        no_gaps = 1'b1;
        for (i = 0; i < 100; i++)
        begin
            send_byte(8'hFF);
        end
        no_gaps = 1'b0;

        for (ph = 0; ph < 10; ph++)
        begin
            settle();
            if ($urandom_range(0, 3) != 0)
            begin
                write_reg(REG_BLOCK_BYTES, pick_block());
            end
            if ($urandom_range(0, 3) != 0)
            begin
                write_reg(REG_LINE_PIXELS, pick_dim());
            end
            if ($urandom_range(0, 3) != 0)
            begin
                write_reg(REG_FRAME_LINES, pick_dim());
            end
            if ($urandom_range(0, 1) != 0)
            begin
                write_reg(REG_WATERFALL, CFG_DATA_W'($urandom_range(0, 131071)));
            end
            no_gaps = ($urandom_range(0, 4) == 0);
            for (i = 0; i < 70; i++)
            begin
                if (i == 35 && ph % 3 == 0)
                begin
                    settle();
                end
                send_byte(pick_byte());
            end
            no_gaps = 1'b0;
        end

        settle();
        if (stats.failures == 0 && stats.pending() == 0)
        begin
            $display("** byte_block_stats_to_pixel: PASSED **");
        end
        else
        begin
            $display("** byte_block_stats_to_pixel: FAILED **");
        end
        $finish;
    end
endmodule
